// ===== src/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned CountBits = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_CLEAR      = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_POP_BACK,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [ValueBits-1:0]   push_value;
  } req_t;

  typedef struct packed {
    logic [ValueBits-1:0]   read_value;
    status_e                status;
    logic                   is_empty;
    logic [CountBits-1:0]   entry_count;
  } rsp_t;

endpackage

// ===== src/dq_cell.sv =====
// One queue slot: a front-ordered word, a back-ordered word and a valid bit.
module dq_cell #(
  parameter int unsigned WordBits = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dq_pkg::cell_op_e     op_i,
  input  logic [WordBits-1:0]  word_i,
  input  logic                 prev_valid_i,
  input  logic [WordBits-1:0]  prev_front_i,
  input  logic [WordBits-1:0]  prev_back_i,
  input  logic                 next_valid_i,
  input  logic [WordBits-1:0]  next_front_i,
  input  logic [WordBits-1:0]  next_back_i,
  output logic                 valid_o,
  output logic [WordBits-1:0]  front_o,
  output logic [WordBits-1:0]  back_o
);
  import dq_pkg::*;

  logic                valid_q, valid_d;
  logic [WordBits-1:0] front_q, front_d;
  logic [WordBits-1:0] back_q, back_d;
  logic                tail;

  // First free slot: the new far-end entry lands here.
  assign tail = prev_valid_i & ~valid_q;

  always_comb begin
    valid_d = valid_q;
    front_d = front_q;
    back_d  = back_q;
    case (op_i)
      CELL_PUSH_FRONT: begin
        valid_d = prev_valid_i;
        front_d = prev_front_i;
        if (tail) begin
          back_d = word_i;
        end
      end
      CELL_PUSH_BACK: begin
        valid_d = prev_valid_i;
        back_d  = prev_back_i;
        if (tail) begin
          front_d = word_i;
        end
      end
      CELL_POP_FRONT: begin
        valid_d = next_valid_i;
        front_d = next_front_i;
      end
      CELL_POP_BACK: begin
        valid_d = next_valid_i;
        back_d  = next_back_i;
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
  end

  assign valid_o = valid_q;
  assign front_o = front_q;
  assign back_o  = back_q;

endmodule

// ===== src/double_ended_queue.sv =====
// Double-ended queue built as a chain of cells, top level.
// The result strobe done_o rises in the cycle after start is accepted.
// Throughput: one transaction per cycle; busy is never raised.
// A push or pop shifts every cell by one place toward its neighbor in the
// same edge.
// Reset clears the valid bits and the count at once; stored words are not reset.
module double_ended_queue #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dq_pkg::req_t  req_i,
  output logic          done_o,
  output dq_pkg::rsp_t  rsp_o
);
  import dq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Chain layout: cell 0 holds the front entry in front_w and the back entry
  // in back_w. Cells 0..count-1 are valid (thermometer code). The front_w
  // row lists entries front to back, the back_w row back to front, so both
  // ends of the queue are always readable at cell 0.
  logic [DEPTH-1:0]     valid;
  logic [WORD_BITS-1:0] front_w [DEPTH];
  logic [WORD_BITS-1:0] back_w  [DEPTH];

  logic [WORD_BITS-1:0] word_in;
  logic [ValueBits-1:0] front_val, back_val;

  logic                 accept;
  logic                 empty, full;
  cell_op_e             cell_op;
  status_e              status;
  logic [ValueBits-1:0] read_val;

  logic [CntW-1:0]      count_q, count_d;
  logic [CountBits-1:0] count_out;
  logic                 done_q;
  rsp_t                 rsp_q, rsp_d;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign empty  = ~valid[0];
  assign full   = valid[DEPTH-1];

  // Width adaptation between the 32-bit ports and the stored word.
  generate
    if (WORD_BITS > ValueBits) begin : g_wide
      assign word_in   = {{(WORD_BITS-ValueBits){1'b0}}, req_i.push_value};
      assign front_val = front_w[0][ValueBits-1:0];
      assign back_val  = back_w[0][ValueBits-1:0];
    end else if (WORD_BITS == ValueBits) begin : g_same
      assign word_in   = req_i.push_value;
      assign front_val = front_w[0];
      assign back_val  = back_w[0];
    end else begin : g_narrow
      assign word_in   = req_i.push_value[WORD_BITS-1:0];
      assign front_val = {{(ValueBits-WORD_BITS){1'b0}}, front_w[0]};
      assign back_val  = {{(ValueBits-WORD_BITS){1'b0}}, back_w[0]};
    end
  endgenerate

  generate
    if (CntW > CountBits) begin : g_cnt_wide
      assign count_out = count_d[CountBits-1:0];
    end else if (CntW == CountBits) begin : g_cnt_same
      assign count_out = count_d;
    end else begin : g_cnt_narrow
      assign count_out = {{(CountBits-CntW){1'b0}}, count_d};
    end
  endgenerate

  // Opcode decode: error cases turn into a hold so the state stays put.
  always_comb begin
    cell_op  = CELL_HOLD;
    status   = ST_OK;
    read_val = '0;
    count_d  = count_q;
    if (accept) begin
      unique case (req_i.opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            cell_op = (req_i.opcode == OP_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_BACK;
            count_d = count_q + CntW'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            cell_op = (req_i.opcode == OP_POP_FRONT) ? CELL_POP_FRONT : CELL_POP_BACK;
            count_d = count_q - CntW'(1);
          end
        end
        OP_PEEK_FRONT, OP_PEEK_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            read_val = (req_i.opcode == OP_PEEK_FRONT) ? front_val : back_val;
          end
        end
        OP_CLEAR: begin
          cell_op = CELL_CLEAR;
          count_d = '0;
        end
        default: begin
          // unused opcode: no-op, status ok
        end
      endcase
    end
  end

  always_comb begin
    rsp_d.read_value  = read_val;
    rsp_d.status      = status;
    rsp_d.is_empty    = (count_d == '0);
    rsp_d.entry_count = count_out;
  end

  // The chain. Cell 0 sees the incoming word as its left neighbor; the last
  // cell sees an invalid, zero right neighbor.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                 pv, nv;
      logic [WORD_BITS-1:0] pf, pb, nf, nb;
      if (gi == 0) begin : g_first
        assign pv = 1'b1;
        assign pf = word_in;
        assign pb = word_in;
      end else begin : g_mid_left
        assign pv = valid[gi-1];
        assign pf = front_w[gi-1];
        assign pb = back_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign nv = 1'b0;
        assign nf = '0;
        assign nb = '0;
      end else begin : g_mid_right
        assign nv = valid[gi+1];
        assign nf = front_w[gi+1];
        assign nb = back_w[gi+1];
      end
      dq_cell #(
        .WordBits (WORD_BITS)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .op_i         (cell_op),
        .word_i       (word_in),
        .prev_valid_i (pv),
        .prev_front_i (pf),
        .prev_back_i  (pb),
        .next_valid_i (nv),
        .next_front_i (nf),
        .next_back_i  (nb),
        .valid_o      (valid[gi]),
        .front_o      (front_w[gi]),
        .back_o       (back_w[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result payload: no reset, qualified by done_o.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Valid bits must stay a thermometer code: a cell is only valid if the one
  // before it is.
  a_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid & ~{valid[DEPTH-2:0], 1'b1}) == '0)
    else $error("valid bits not contiguous from cell 0");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid) == 32'(count_q))
    else $error("count out of step with valid cells");

  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without a transaction");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> count_q == CntW'(DEPTH))
    else $error("full status with room left");

endmodule
